// ===== rtl/lef_pkg.sv =====
// shared types, constants and update helpers for the leader election controller
package lef_pkg;

   localparam int TIMER_BITS = 16;
   localparam int ID_BITS = 22;
   localparam int AGE_BITS = 16;
   localparam int LIMIT_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};
   localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

   localparam logic [2:0] MODE_TICK = 3'd0;
   localparam logic [2:0] MODE_HEARTBEAT = 3'd1;
   localparam logic [2:0] MODE_ELECTION_START = 3'd2;
   localparam logic [2:0] MODE_CANDIDATE = 3'd3;
   localparam logic [2:0] MODE_LEADER_CLAIM = 3'd4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_OWN_ID = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_AS_LEADER = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEARTBEAT_TIMEOUT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ELECTION = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEARTBEAT_PERIOD = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STARTUP_DELAY = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RETRY = 3'd6;

   localparam logic [1:0] ROLE_CODE_FOLLOWER = 2'd0;
   localparam logic [1:0] ROLE_CODE_ELECTION = 2'd1;
   localparam logic [1:0] ROLE_CODE_LEADER = 2'd2;

   typedef enum logic [2:0] {
      ROLE_FOLLOWER = 3'b001,
      ROLE_ELECTION = 3'b010,
      ROLE_LEADER   = 3'b100
   } role_type;

   typedef struct packed {
      logic                  run;
      logic [TIMER_BITS-1:0] cnt;
   } timer_type;

   typedef struct packed {
      timer_type tmr;
      logic      fired;
   } tick_result_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    own_id;
      logic                  start_as_leader;
      logic [LIMIT_BITS-1:0] heartbeat_timeout_ms;
      logic [LIMIT_BITS-1:0] election_ms;
      logic [LIMIT_BITS-1:0] heartbeat_period_ms;
      logic [LIMIT_BITS-1:0] startup_delay_ms;
      logic [LIMIT_BITS-1:0] retry_ms;
   } cfg_type;

   typedef struct packed {
      role_type              role;
      logic                  started;
      logic                  holding_off;
      logic                  election_active;
      logic [AGE_BITS-1:0]   beat_age;
      timer_type             check_phase;
      timer_type             election_phase;
      timer_type             retry_phase;
      timer_type             beat_phase;
      logic [TIMER_BITS-1:0] holdoff_count;
      logic                  top_empty;
      logic [ID_BITS-1:0]    top_candidate;
   } state_type;

   typedef struct packed {
      logic beat;
      logic elec;
      logic cand;
      logic claim;
   } flags_type;

   typedef struct packed {
      state_type st;
      flags_type fl;
   } work_type;

   localparam timer_type TIMER_STOP = '{run: 1'b0, cnt: '0};
   localparam timer_type TIMER_START = '{run: 1'b1, cnt: '0};

   localparam cfg_type CFG_RESET = '{
      own_id: 22'd1,
      start_as_leader: 1'b0,
      heartbeat_timeout_ms: 16'd10000,
      election_ms: 16'd2000,
      heartbeat_period_ms: 16'd5000,
      startup_delay_ms: 16'd3000,
      retry_ms: 16'd3000
   };

   localparam state_type STATE_RESET = '{
      role: ROLE_FOLLOWER,
      started: 1'b0,
      holding_off: 1'b1,
      election_active: 1'b0,
      beat_age: '0,
      check_phase: TIMER_STOP,
      election_phase: TIMER_STOP,
      retry_phase: TIMER_STOP,
      beat_phase: TIMER_STOP,
      holdoff_count: '0,
      top_empty: 1'b1,
      top_candidate: '0
   };

   function automatic logic [TIMER_BITS-1:0] sat_inc(logic [TIMER_BITS-1:0] v);
      return (v != CNT_MAX) ? v + 1'b1 : v;
   endfunction

   // limit clamped to the counter maximum, zero behaves as one
   function automatic logic reached(logic [TIMER_BITS-1:0] cnt,
                                    logic [LIMIT_BITS-1:0] limit);
      logic [32:0] lim;
      lim = 33'(limit);
      if (lim > 33'(CNT_MAX)) begin
         lim = 33'(CNT_MAX);
      end
      return 33'(cnt) >= lim;
   endfunction

   function automatic tick_result_type timer_tick(timer_type t,
                                                  logic [LIMIT_BITS-1:0] limit);
      tick_result_type r;
      r.tmr = t;
      r.fired = 1'b0;
      if (t.run) begin
         r.tmr.cnt = sat_inc(t.cnt);
         if (reached(r.tmr.cnt, limit)) begin
            r.tmr.cnt = '0;
            r.fired = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic muted(state_type s);
      return s.holding_off && (s.role == ROLE_FOLLOWER);
   endfunction

   function automatic work_type clear_election(work_type w);
      w.st.election_active = 1'b0;
      w.st.top_empty = 1'b1;
      w.st.top_candidate = '0;
      w.st.election_phase = TIMER_STOP;
      return w;
   endfunction

   function automatic work_type enter_election(work_type w, logic [ID_BITS-1:0] own);
      if (!muted(w.st) && !w.st.election_active) begin
         w.st.election_active = 1'b1;
         w.st.role = ROLE_ELECTION;
         w.st.check_phase = TIMER_STOP;
         w.st.beat_phase = TIMER_STOP;
         w.fl.cand = 1'b1;
         w.st.top_empty = 1'b0;
         w.st.top_candidate = own;
         w.st.election_phase = TIMER_START;
      end
      return w;
   endfunction

   function automatic work_type call_election(work_type w, logic [ID_BITS-1:0] own);
      if (!muted(w.st) && !w.st.election_active) begin
         w.fl.elec = 1'b1;
         w = enter_election(w, own);
      end
      return w;
   endfunction

   function automatic logic [1:0] role_code(role_type r);
      logic [1:0] c;
      case (r)
         ROLE_FOLLOWER: c = ROLE_CODE_FOLLOWER;
         ROLE_ELECTION: c = ROLE_CODE_ELECTION;
         ROLE_LEADER: c = ROLE_CODE_LEADER;
         default: c = ROLE_CODE_FOLLOWER;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/lef_step.sv =====
// next-state and message-flag logic for one tick or received message
module lef_step import lef_pkg::*; (
   input  cfg_type            cfg,
   input  state_type          cur_state,
   input  logic [2:0]         mode,
   input  logic [ID_BITS-1:0] peer_id,
   output state_type          next_state,
   output flags_type          flags
);

   work_type        w;
   tick_result_type t_chk;
   tick_result_type t_el;
   tick_result_type t_rt;
   tick_result_type t_bt;
   logic [ID_BITS-1:0] best;

   always_comb begin
      w.st = cur_state;
      w.fl = '0;
      t_chk = '0;
      t_el = '0;
      t_rt = '0;
      t_bt = '0;
      best = '0;

      // first item after reset applies the start role
      if (!w.st.started) begin
         w.st.started = 1'b1;
         if (cfg.start_as_leader) begin
            w.st.holding_off = 1'b0;
            w.st.role = ROLE_LEADER;
            w = call_election(w, cfg.own_id);
         end else begin
            w.st.role = ROLE_FOLLOWER;
            w.st.beat_age = '0;
            w.st.holdoff_count = '0;
         end
      end

      case (mode)
         MODE_TICK: begin
            if (w.st.beat_age != AGE_MAX) begin
               w.st.beat_age = w.st.beat_age + 1'b1;
            end
            if (w.st.holding_off) begin
               w.st.holdoff_count = sat_inc(w.st.holdoff_count);
               if (reached(w.st.holdoff_count, cfg.startup_delay_ms)) begin
                  w.st.holding_off = 1'b0;
                  if (w.st.beat_age > cfg.heartbeat_timeout_ms) begin
                     w = call_election(w, cfg.own_id);
                  end else begin
                     w.st.check_phase = TIMER_START;
                  end
               end
            end
            t_chk = timer_tick(w.st.check_phase, cfg.heartbeat_timeout_ms);
            w.st.check_phase = t_chk.tmr;
            if (t_chk.fired && !w.st.holding_off && w.st.role == ROLE_FOLLOWER &&
                w.st.beat_age > cfg.heartbeat_timeout_ms) begin
               w = call_election(w, cfg.own_id);
            end
            t_el = timer_tick(w.st.election_phase, cfg.election_ms);
            w.st.election_phase = t_el.tmr;
            if (t_el.fired) begin
               w.st.election_phase = TIMER_STOP;
               if (w.st.role == ROLE_ELECTION) begin
                  best = w.st.top_empty ? cfg.own_id : w.st.top_candidate;
                  if (best == cfg.own_id) begin
                     w.fl.claim = 1'b1;
                     w = clear_election(w);
                  end else begin
                     w.st.retry_phase = TIMER_START;
                  end
               end
            end
            t_rt = timer_tick(w.st.retry_phase, cfg.retry_ms);
            w.st.retry_phase = t_rt.tmr;
            if (t_rt.fired) begin
               w.st.retry_phase = TIMER_STOP;
               if (w.st.role == ROLE_ELECTION) begin
                  w = clear_election(w);
                  w = call_election(w, cfg.own_id);
               end
            end
            t_bt = timer_tick(w.st.beat_phase, cfg.heartbeat_period_ms);
            w.st.beat_phase = t_bt.tmr;
            if (t_bt.fired && w.st.role == ROLE_LEADER) begin
               w.fl.beat = 1'b1;
            end
         end
         MODE_HEARTBEAT: begin
            if (!muted(w.st) && w.st.role == ROLE_FOLLOWER) begin
               w.st.beat_age = '0;
            end
         end
         MODE_ELECTION_START: begin
            w = enter_election(w, cfg.own_id);
         end
         MODE_CANDIDATE: begin
            if (!muted(w.st) && w.st.role == ROLE_ELECTION &&
                (w.st.top_empty || peer_id > w.st.top_candidate)) begin
               w.st.top_empty = 1'b0;
               w.st.top_candidate = peer_id;
            end
         end
         MODE_LEADER_CLAIM: begin
            if (!muted(w.st) && w.st.role != ROLE_FOLLOWER) begin
               if (peer_id == cfg.own_id) begin
                  if (w.st.role == ROLE_ELECTION) begin
                     w.st.role = ROLE_LEADER;
                     w.st.check_phase = TIMER_STOP;
                     w.st.beat_phase = TIMER_START;
                     w.fl.beat = 1'b1;
                     w = clear_election(w);
                  end
               end else if (peer_id > cfg.own_id) begin
                  w.st.beat_phase = TIMER_STOP;
                  w.st.role = ROLE_FOLLOWER;
                  w = clear_election(w);
                  w.st.beat_age = '0;
                  if (!w.st.holding_off) begin
                     w.st.check_phase = TIMER_START;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign next_state = w.st;
   assign flags = w.fl;

endmodule

// ===== rtl/leader_election_fsm_unit.sv =====
// leader election controller top level: config registers, state and result register
// each result is registered on its item transfer and shown in the cycle after it
// throughput: one item per cycle while req_stall is low, set by the state update
// req_stall is high only while a held result is stalled on the rsp side
// reset: synchronous; all but result payload registers reset; the node restarts
module leader_election_fsm_unit import lef_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_mode,
   input  logic [ID_BITS-1:0]        req_peer_id,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_role,
   output logic                      rsp_send_heartbeat,
   output logic                      rsp_send_election_start,
   output logic                      rsp_send_candidacy,
   output logic                      rsp_send_leader_claim,
   output logic [ID_BITS-1:0]        rsp_best_candidate,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ID_BITS-1:0]        csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff;
   state_type state_in;
   flags_type step_flags;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [1:0]         role_ff;
   flags_type          flags_ff;
   logic [ID_BITS-1:0] best_ff;
   logic               req_xfer;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer = req_valid && !req_stall;

   lef_step u_step (
      .cfg        (cfg_ff),
      .cur_state  (state_ff),
      .mode       (req_mode),
      .peer_id    (req_peer_id),
      .next_state (state_in),
      .flags      (step_flags)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OWN_ID: cfg_in.own_id = csr_wdata;
            CSR_START_AS_LEADER: cfg_in.start_as_leader = csr_wdata[0];
            CSR_HEARTBEAT_TIMEOUT: cfg_in.heartbeat_timeout_ms = csr_wdata[LIMIT_BITS-1:0];
            CSR_ELECTION: cfg_in.election_ms = csr_wdata[LIMIT_BITS-1:0];
            CSR_HEARTBEAT_PERIOD: cfg_in.heartbeat_period_ms = csr_wdata[LIMIT_BITS-1:0];
            CSR_STARTUP_DELAY: cfg_in.startup_delay_ms = csr_wdata[LIMIT_BITS-1:0];
            CSR_RETRY: cfg_in.retry_ms = csr_wdata[LIMIT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = req_xfer || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
         state_ff <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            state_ff <= state_in;
         end
      end
   end

   // result payload, loaded on each item transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         role_ff <= role_code(state_in.role);
         flags_ff <= step_flags;
         best_ff <= state_in.top_empty ? '0 : state_in.top_candidate;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_role = role_ff;
   assign rsp_send_heartbeat = flags_ff.beat;
   assign rsp_send_election_start = flags_ff.elec;
   assign rsp_send_candidacy = flags_ff.cand;
   assign rsp_send_leader_claim = flags_ff.claim;
   assign rsp_best_candidate = best_ff;

endmodule

// ===== rtl/lef_checker.sv =====
// port-level checks for the leader election controller and their bind
module lef_checker import lef_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic [2:0]                req_mode,
   input logic [ID_BITS-1:0]        req_peer_id,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [1:0]                rsp_role,
   input logic                      rsp_send_heartbeat,
   input logic                      rsp_send_election_start,
   input logic                      rsp_send_candidacy,
   input logic                      rsp_send_leader_claim,
   input logic [ID_BITS-1:0]        rsp_best_candidate
);

   // every request transfer yields a result in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("request transfer without result");

   // backpressure only passes through while a result is held
   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result pending");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_role) && $stable(rsp_best_candidate) &&
         $stable(rsp_send_leader_claim) && $stable(rsp_send_heartbeat) &&
         $stable(rsp_send_election_start) && $stable(rsp_send_candidacy))
      else $error("stalled result changed");

   a_req_stable: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_mode) && $stable(req_peer_id))
      else $error("stalled request changed");

endmodule

bind leader_election_fsm_unit lef_checker u_lef_checker (.*);

// ===== test/lef_election_checker.sv =====
// predicts leader election results from observed transfers and compares them with the rsp channel
module lef_election_checker import lef_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [2:0]                req_mode,
   input  logic [ID_BITS-1:0]        req_peer_id,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [1:0]                rsp_role,
   input  logic                      rsp_send_heartbeat,
   input  logic                      rsp_send_election_start,
   input  logic                      rsp_send_candidacy,
   input  logic                      rsp_send_leader_claim,
   input  logic [ID_BITS-1:0]        rsp_best_candidate,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ID_BITS-1:0]        csr_wdata,
   output int                        fail_count,
   output int                        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PH_CHECK = 0;
   localparam int PH_ELECT = 1;
   localparam int PH_RETRY = 2;
   localparam int PH_BEAT = 3;

   typedef struct packed {
      logic [1:0]         role;
      logic               beat;
      logic               elec;
      logic               cand;
      logic               claim;
      logic [ID_BITS-1:0] best;
   } outcome_type;

   // register copies
   logic [ID_BITS-1:0]    own_id;
   logic                  lead_at_start;
   logic [LIMIT_BITS-1:0] beat_timeout;
   logic [LIMIT_BITS-1:0] elect_len;
   logic [LIMIT_BITS-1:0] beat_period;
   logic [LIMIT_BITS-1:0] startup_len;
   logic [LIMIT_BITS-1:0] retry_len;

   // node state
   logic [1:0]            node_role;
   bit                    started;
   bit                    holding_off;
   bit                    in_election;
   logic [AGE_BITS-1:0]   beat_age;
   logic [TIMER_BITS-1:0] holdoff_count;
   bit                    top_empty;
   logic [ID_BITS-1:0]    top_id;
   bit                    phase_run [4];
   logic [TIMER_BITS-1:0] phase_cnt [4];
   bit                    f_beat, f_elec, f_cand, f_claim;

   outcome_type outcomes[$];

   task flag_failure(input string msg);
      $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   task check_field(input string name, input longint got, input longint want);
      if (got != want) begin
         flag_failure($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
      end
   endtask

   function logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   function bit hit(input logic [TIMER_BITS-1:0] cnt, input logic [LIMIT_BITS-1:0] lim);
      longint l;
      l = longint'(lim);
      if (l > longint'(CNT_MAX)) begin
         l = longint'(CNT_MAX);
      end
      return longint'(cnt) >= l;
   endfunction

   function void start_phase(input int i);
      phase_run[i] = 1'b1;
      phase_cnt[i] = '0;
   endfunction

   function void stop_phase(input int i);
      phase_run[i] = 1'b0;
      phase_cnt[i] = '0;
   endfunction

   function bit advance(input int i, input logic [LIMIT_BITS-1:0] lim);
      if (!phase_run[i]) begin
         return 1'b0;
      end
      phase_cnt[i] = bump(phase_cnt[i]);
      if (hit(phase_cnt[i], lim)) begin
         phase_cnt[i] = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function bit is_muted();
      return holding_off && node_role == ROLE_CODE_FOLLOWER;
   endfunction

   function void drop_election();
      in_election = 1'b0;
      top_empty = 1'b1;
      top_id = '0;
      stop_phase(PH_ELECT);
   endfunction

   function void join_election();
      if (is_muted() || in_election) begin
         return;
      end
      in_election = 1'b1;
      node_role = ROLE_CODE_ELECTION;
      stop_phase(PH_CHECK);
      stop_phase(PH_BEAT);
      f_cand = 1'b1;
      top_empty = 1'b0;
      top_id = own_id;
      start_phase(PH_ELECT);
   endfunction

   function void call_election();
      if (is_muted() || in_election) begin
         return;
      end
      f_elec = 1'b1;
      join_election();
   endfunction

   function void on_tick();
      logic [ID_BITS-1:0] best;
      if (beat_age != AGE_MAX) begin
         beat_age = beat_age + 1'b1;
      end
      if (holding_off) begin
         holdoff_count = bump(holdoff_count);
         if (hit(holdoff_count, startup_len)) begin
            holding_off = 1'b0;
            if (beat_age > beat_timeout) begin
               call_election();
            end else begin
               start_phase(PH_CHECK);
            end
         end
      end
      if (advance(PH_CHECK, beat_timeout)) begin
         if (!holding_off && node_role == ROLE_CODE_FOLLOWER && beat_age > beat_timeout) begin
            call_election();
         end
      end
      if (advance(PH_ELECT, elect_len)) begin
         stop_phase(PH_ELECT);
         if (node_role == ROLE_CODE_ELECTION) begin
            best = top_empty ? own_id : top_id;
            if (best == own_id) begin
               f_claim = 1'b1;
               drop_election();
            end else begin
               start_phase(PH_RETRY);
            end
         end
      end
      if (advance(PH_RETRY, retry_len)) begin
         stop_phase(PH_RETRY);
         if (node_role == ROLE_CODE_ELECTION) begin
            drop_election();
            call_election();
         end
      end
      if (advance(PH_BEAT, beat_period)) begin
         if (node_role == ROLE_CODE_LEADER) begin
            f_beat = 1'b1;
         end
      end
   endfunction

   function void on_claim(input logic [ID_BITS-1:0] peer);
      if (is_muted() || node_role == ROLE_CODE_FOLLOWER) begin
         return;
      end
      if (peer == own_id) begin
         if (node_role == ROLE_CODE_ELECTION) begin
            node_role = ROLE_CODE_LEADER;
            stop_phase(PH_CHECK);
            start_phase(PH_BEAT);
            f_beat = 1'b1;
            drop_election();
         end
      end else if (peer > own_id) begin
         stop_phase(PH_BEAT);
         node_role = ROLE_CODE_FOLLOWER;
         drop_election();
         beat_age = '0;
         if (!holding_off) begin
            start_phase(PH_CHECK);
         end
      end
   endfunction

   function void predict_item(input logic [2:0] mode, input logic [ID_BITS-1:0] peer);
      outcome_type o;
      f_beat = 1'b0;
      f_elec = 1'b0;
      f_cand = 1'b0;
      f_claim = 1'b0;
      if (!started) begin
         started = 1'b1;
         if (lead_at_start) begin
            holding_off = 1'b0;
            node_role = ROLE_CODE_LEADER;
            call_election();
         end else begin
            node_role = ROLE_CODE_FOLLOWER;
            beat_age = '0;
            holdoff_count = '0;
         end
      end
      case (mode)
         MODE_TICK: on_tick();
         MODE_HEARTBEAT: begin
            if (!is_muted() && node_role == ROLE_CODE_FOLLOWER) begin
               beat_age = '0;
            end
         end
         MODE_ELECTION_START: join_election();
         MODE_CANDIDATE: begin
            if (!is_muted() && node_role == ROLE_CODE_ELECTION && (top_empty || peer > top_id)) begin
               top_empty = 1'b0;
               top_id = peer;
            end
         end
         MODE_LEADER_CLAIM: on_claim(peer);
         default: ;
      endcase
      o.role = node_role;
      o.beat = f_beat;
      o.elec = f_elec;
      o.cand = f_cand;
      o.claim = f_claim;
      o.best = top_empty ? '0 : top_id;
      outcomes.push_back(o);
   endfunction

   function void write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                input logic [ID_BITS-1:0] value);
      case (idx)
         CSR_OWN_ID: own_id = value;
         CSR_START_AS_LEADER: lead_at_start = value[0];
         CSR_HEARTBEAT_TIMEOUT: beat_timeout = value[LIMIT_BITS-1:0];
         CSR_ELECTION: elect_len = value[LIMIT_BITS-1:0];
         CSR_HEARTBEAT_PERIOD: beat_period = value[LIMIT_BITS-1:0];
         CSR_STARTUP_DELAY: startup_len = value[LIMIT_BITS-1:0];
         CSR_RETRY: retry_len = value[LIMIT_BITS-1:0];
         default: ;
      endcase
   endfunction

   function void restart();
      int i;
      own_id = 22'd1;
      lead_at_start = 1'b0;
      beat_timeout = 16'd10000;
      elect_len = 16'd2000;
      beat_period = 16'd5000;
      startup_len = 16'd3000;
      retry_len = 16'd3000;
      node_role = ROLE_CODE_FOLLOWER;
      started = 1'b0;
      holding_off = 1'b1;
      in_election = 1'b0;
      beat_age = '0;
      holdoff_count = '0;
      top_empty = 1'b1;
      top_id = '0;
      for (i = 0; i < 4; i++) begin
         stop_phase(i);
      end
      outcomes.delete();
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         restart();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcomes.size() == 0) begin
               flag_failure("result transfer with no item waiting");
            end else begin
               want = outcomes.pop_front();
               check_field("role", rsp_role, want.role);
               check_field("send_heartbeat", rsp_send_heartbeat, want.beat);
               check_field("send_election_start", rsp_send_election_start, want.elec);
               check_field("send_candidacy", rsp_send_candidacy, want.cand);
               check_field("send_leader_claim", rsp_send_leader_claim, want.claim);
               check_field("best_candidate", rsp_best_candidate, want.best);
            end
         end
         if (csr_valid && csr_ready) begin
            write_register(csr_index, csr_wdata);
         end
         if (req_valid && !req_stall) begin
            predict_item(req_mode, req_peer_id);
         end
      end
      pending_count = outcomes.size();
   end

endmodule

// ===== test/leader_election_fsm_unit_tb.sv =====
// top of the leader election controller testbench: clock, reset, stimulus and verdict
module leader_election_fsm_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lef_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD = 400;
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam logic [ID_BITS-1:0] ID_TOP = '1;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [2:0]                req_mode;
   logic [ID_BITS-1:0]        req_peer_id;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [1:0]                rsp_role;
   logic                      rsp_send_heartbeat;
   logic                      rsp_send_election_start;
   logic                      rsp_send_candidacy;
   logic                      rsp_send_leader_claim;
   logic [ID_BITS-1:0]        rsp_best_candidate;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [ID_BITS-1:0]        csr_wdata;

   int                        fail_count;
   int                        pending_count;
   int                        cycles = 0;
   bit                        req_idle = 1'b1;
   bit                        rsp_idle = 1'b1;
   bit                        hold_req = 1'b0;
   logic [ID_BITS-1:0]        cur_own;

   leader_election_fsm_unit i_dut (.*);

   lef_election_checker i_checker (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("leader_election_fsm_unit verification failed");
         $finish;
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin : rsp_side
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall = 1'b1;
            for (n = 0; n < LONG_HOLD; n++) begin
               @(negedge clock);
            end
            rsp_stall = 1'b0;
         end else if (rsp_idle && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic offer(input logic [2:0] mode, input logic [ID_BITS-1:0] peer);
      int gap;
      if (req_idle && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 11);
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode = mode;
      req_peer_id = peer;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [ID_BITS-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // limit writes carry random upper bits that the block must drop
   task automatic set_limits(input logic [15:0] timeout, input logic [15:0] elect,
                             input logic [15:0] period, input logic [15:0] startup,
                             input logic [15:0] retry);
      configure(CSR_HEARTBEAT_TIMEOUT, {6'($urandom), timeout});
      configure(CSR_ELECTION, {6'($urandom), elect});
      configure(CSR_HEARTBEAT_PERIOD, {6'($urandom), period});
      configure(CSR_STARTUP_DELAY, {6'($urandom), startup});
      configure(CSR_RETRY, {6'($urandom), retry});
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [ID_BITS-1:0] pick_peer();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         return cur_own;
      end else if (r < 55) begin
         return cur_own + ID_BITS'($urandom_range(1, 3));
      end else if (r < 70) begin
         return cur_own - ID_BITS'($urandom_range(1, 3));
      end else if (r < 90) begin
         return ID_BITS'($urandom);
      end else if (r < 95) begin
         return '0;
      end
      return ID_TOP;
   endfunction

   task automatic run_random(input int count, input int hold_at);
      int i;
      int r;
      logic [2:0] m;
      for (i = 0; i < count; i++) begin
         if (i == hold_at) begin
            hold_req = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 45) begin
            m = MODE_TICK;
         end else if (r < 55) begin
            m = MODE_HEARTBEAT;
         end else if (r < 62) begin
            m = MODE_ELECTION_START;
         end else if (r < 78) begin
            m = MODE_CANDIDATE;
         end else if (r < 96) begin
            m = MODE_LEADER_CLAIM;
         end else begin
            m = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
         end
         offer(m, pick_peer());
      end
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_TICK;
      req_peer_id = '0;
      csr_valid = 1'b0;
      csr_index = CSR_OWN_ID;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // start-up, hold-off, won and lost elections, retry, claims
      cur_own = 22'd100;
      configure(CSR_OWN_ID, cur_own);
      configure(CSR_START_AS_LEADER, ID_BITS'($urandom_range(0, 1)));
      set_limits(16'd3, 16'd3, 16'd2, 16'd2, 16'd3);
      offer(MODE_HEARTBEAT, '0);
      offer(MODE_CANDIDATE, 22'd200);
      repeat (2) offer(MODE_TICK, '0);
      offer(MODE_ELECTION_START, '0);
      offer(MODE_CANDIDATE, 22'd50);
      offer(MODE_CANDIDATE, '0);
      repeat (3) offer(MODE_TICK, '0);
      offer(MODE_LEADER_CLAIM, cur_own);
      repeat (2) offer(MODE_TICK, '0);
      offer(MODE_ELECTION_START, '0);
      offer(MODE_CANDIDATE, ID_TOP);
      repeat (3) offer(MODE_TICK, '0);
      offer(MODE_LEADER_CLAIM, 22'd50);
      repeat (3) offer(MODE_TICK, '0);
      offer(MODE_LEADER_CLAIM, ID_TOP);
      offer(MODE_HEARTBEAT, '0);
      offer(MODE_SPARE_LO, ID_TOP);
      offer(MODE_SPARE_HI, 22'd7);
      run_random(360, -1);
      settle();

      // lowest id and shortest limits
      cur_own = '0;
      configure(CSR_OWN_ID, cur_own);
      configure(CSR_START_AS_LEADER, '0);
      set_limits(16'd1, 16'd1, 16'd1, 16'd0, 16'd1);
      configure(CSR_UNUSED, ID_BITS'($urandom));
      run_random(380, -1);
      settle();

      // highest id and longest limits but for the election, no idling
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      cur_own = ID_TOP;
      configure(CSR_OWN_ID, cur_own);
      configure(CSR_START_AS_LEADER, ID_TOP);
      set_limits(16'hFFFF, 16'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random(300, -1);
      settle();

      // random settings with one long result hold-off
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      cur_own = ID_BITS'($urandom);
      configure(CSR_OWN_ID, cur_own);
      set_limits(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                 16'($urandom_range(1, 12)), 16'($urandom_range(0, 12)),
                 16'($urandom_range(1, 12)));
      run_random(420, 100);
      settle();

      // closing stretch without idling
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      cur_own = ID_BITS'($urandom_range(0, 1000));
      configure(CSR_OWN_ID, cur_own);
      set_limits(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                 16'($urandom_range(1, 8)), 16'($urandom_range(0, 8)),
                 16'($urandom_range(1, 8)));
      run_random(470, -1);
      settle();

      if (fail_count == 0) begin
         $display("leader_election_fsm_unit verification clean");
      end else begin
         $display("leader_election_fsm_unit verification failed");
      end
      $finish;
   end

endmodule
